// ===== rtl/sitoa_pkg.sv =====
package sitoa_pkg;

   // Field widths.
   localparam int ValueWidth = 32;
   localparam int CharWidth = 8;

   // Decimal text of a 32-bit magnitude needs at most ten digits.
   localparam int NumDigits = 10;
   localparam int BcdWidth = 4 * NumDigits;
   localparam int DigitIdxWidth = 4;
   localparam logic [DigitIdxWidth-1:0] DigitIdxMax = DigitIdxWidth'(NumDigits - 1);

   // Shift-and-add-3 conversion: eight steps per pipeline stage.
   localparam int StepsPerStage = 8;
   localparam int DabbleStages = ValueWidth / StepsPerStage;

   // Character codes.
   localparam logic [CharWidth-1:0] CharZero = 8'd48;
   localparam logic [CharWidth-1:0] CharMinus = 8'd45;

   // Payload of one conversion pipeline stage.
   typedef struct packed {
      logic                  neg;
      logic [BcdWidth-1:0]   bcd;
      logic [ValueWidth-1:0] bin;
   } dabble_type;

   // Runs one stage worth of shift-and-add-3 steps, consuming the top bits of bin.
   function automatic dabble_type dabble_steps(dabble_type d);
      dabble_type r;
      r = d;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int n = 0; n < NumDigits; n++) begin
            if (r.bcd[4*n +: 4] >= 4'd5) begin
               r.bcd[4*n +: 4] = r.bcd[4*n +: 4] + 4'd3;
            end
         end
         {r.bcd, r.bin} = {r.bcd[BcdWidth-2:0], r.bin, 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== rtl/sitoa_if.sv =====
// Input channel: one signed integer per beat.
interface sitoa_req_if import sitoa_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// Result channel: one ASCII character per beat.
interface sitoa_rsp_if import sitoa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;
   logic                 is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink (input valid, input char_code, input is_last, output ready);
endinterface

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Channel   Direction  Payload                      Beat
// req_if    in         value[31:0], signed          one integer
// rsp_if    out        char_code[7:0], is_last      one character
//
// An integer passes a capture stage and four conversion stages (eight
// shift-and-add-3 steps each), then waits in the character serializer.
// The serializer sends one character per cycle while rsp_if is ready, so one
// integer's text is 1 to 11 characters: the digit count, plus one for a minus sign.
// Reset is synchronous and clears all valid bits; no state spans integers.
// A stall on rsp_if holds the output register and backs up the pipeline stage
// by stage; nothing is dropped or repeated.
module signed_int_to_decimal_ascii_top
   import sitoa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   sitoa_req_if.sink          req_if,
   sitoa_rsp_if.source        rsp_if
);

   localparam int LastStage = DabbleStages;

   // Conversion pipeline registers; stage 0 holds the captured magnitude.
   dabble_type                pipe_ff [0:LastStage];
   dabble_type                pipe_in [0:LastStage];
   logic [LastStage:0]        pipe_valid_ff;
   logic [LastStage:0]        stage_adv;
   logic [LastStage:0]        stage_load;

   // Serializer registers.
   logic                      ser_valid_ff;
   logic                      ser_neg_ff;
   logic [BcdWidth-1:0]       ser_bcd_ff;
   logic [DigitIdxWidth-1:0]  ser_idx_ff;
   logic                      ser_neg_in;
   logic [DigitIdxWidth-1:0]  ser_idx_in;
   logic [DigitIdxWidth-1:0]  lead_idx;
   logic [3:0]                cur_digit;
   logic                      ser_emit;
   logic                      ser_emit_last;
   logic                      ser_load;

   // Output register.
   logic                      rsp_valid_ff;
   logic [CharWidth-1:0]      rsp_char_ff;
   logic                      rsp_last_ff;
   logic [CharWidth-1:0]      rsp_char_in;
   logic                      rsp_last_in;

   logic                      in_neg;
   logic [ValueWidth-1:0]     in_raw;

   // Capture stage input: sign and magnitude; the most negative value maps to 2^31.
   assign in_raw = ValueWidth'(req_if.value);
   assign in_neg = in_raw[ValueWidth-1];
   always_comb begin
      pipe_in[0].neg = in_neg;
      pipe_in[0].bcd = '0;
      pipe_in[0].bin = in_neg ? (~in_raw + ValueWidth'(1)) : in_raw;
      for (int k = 1; k <= LastStage; k++) begin
         pipe_in[k] = dabble_steps(pipe_ff[k-1]);
      end
   end

   // Serializer emits when the output register is free or being drained.
   assign ser_emit = ser_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign ser_emit_last = ser_emit && !ser_neg_ff && (ser_idx_ff == '0);
   assign ser_load = pipe_valid_ff[LastStage] && (!ser_valid_ff || ser_emit_last);

   // Stage advance chain, from the serializer back to the input.
   always_comb begin
      stage_adv[LastStage] = ser_load;
      for (int k = LastStage - 1; k >= 0; k--) begin
         stage_adv[k] = pipe_valid_ff[k] && (!pipe_valid_ff[k+1] || stage_adv[k+1]);
      end
      stage_load[0] = req_if.valid && req_if.ready;
      for (int k = 1; k <= LastStage; k++) begin
         stage_load[k] = stage_adv[k-1];
      end
   end

   assign req_if.ready = !pipe_valid_ff[0] || stage_adv[0];

   // Position of the most significant nonzero digit; zero gives digit 0.
   always_comb begin
      lead_idx = '0;
      for (int n = 0; n < NumDigits; n++) begin
         if (pipe_ff[LastStage].bcd[4*n +: 4] != 4'd0) begin
            lead_idx = DigitIdxWidth'(n);
         end
      end
   end

   // Digit under the serializer's index.
   always_comb begin
      cur_digit = 4'd0;
      for (int n = 0; n < NumDigits; n++) begin
         if (ser_idx_ff == DigitIdxWidth'(n)) begin
            cur_digit = ser_bcd_ff[4*n +: 4];
         end
      end
   end

   // Next character and serializer position.
   always_comb begin
      ser_neg_in = ser_neg_ff;
      ser_idx_in = ser_idx_ff;
      rsp_char_in = CharZero + {4'd0, cur_digit};
      rsp_last_in = (ser_idx_ff == '0);
      if (ser_neg_ff) begin
         rsp_char_in = CharMinus;
         rsp_last_in = 1'b0;
         ser_neg_in = 1'b0;
      end else if (ser_idx_ff != '0) begin
         ser_idx_in = ser_idx_ff - DigitIdxWidth'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
         ser_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k <= LastStage; k++) begin
            if (stage_load[k]) begin
               pipe_valid_ff[k] <= 1'b1;
            end else if (stage_adv[k]) begin
               pipe_valid_ff[k] <= 1'b0;
            end
         end
         if (ser_load) begin
            ser_valid_ff <= 1'b1;
         end else if (ser_emit_last) begin
            ser_valid_ff <= 1'b0;
         end
         if (ser_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int k = 0; k <= LastStage; k++) begin
         if (stage_load[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (ser_load) begin
         ser_neg_ff <= pipe_ff[LastStage].neg;
         ser_bcd_ff <= pipe_ff[LastStage].bcd;
         ser_idx_ff <= lead_idx;
      end else if (ser_emit) begin
         ser_neg_ff <= ser_neg_in;
         ser_idx_ff <= ser_idx_in;
      end
      if (ser_emit) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.char_code = rsp_char_ff;
   assign rsp_if.is_last = rsp_last_ff;

   // A minus sign is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_char_ff == CharMinus) |-> !rsp_last_ff)
      else $error("minus sign flagged as last character");

   // Every character sent is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_char_ff == CharMinus) ||
                        (rsp_char_ff >= CharZero && rsp_char_ff <= CharZero + 8'd9)))
      else $error("character outside the decimal set");

   // The serializer index stays within the ten digit positions.
   assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (ser_idx_ff <= DigitIdxMax))
      else $error("serializer index out of range");

   // A new integer enters the serializer only after the previous text has finished.
   assert property (@(posedge clock) disable iff (reset)
      (ser_load && ser_valid_ff) |-> (!ser_neg_ff && ser_idx_ff == '0 && ser_emit))
      else $error("serializer reloaded before its text was sent");

   // A finished integer leaves the last stage only into the serializer.
   assert property (@(posedge clock) disable iff (reset)
      ser_load |=> ser_valid_ff)
      else $error("serializer load lost");

endmodule
